>>> hdl/awbgc_pkg.sv
package awbgc_pkg;

   // record layout
   localparam int RECORD_BYTES = 30;
   localparam int LAST_POS     = RECORD_BYTES - 1;
   localparam int CHAN_FIRST   = 13;
   localparam int CHAN_COUNT   = 16;
   localparam int CHAN_IDX_W   = $clog2(CHAN_COUNT);
   localparam int SET_BYTES    = CHAN_COUNT / 2;
   localparam int POS_W        = $clog2(RECORD_BYTES + 1);
   localparam int SUM_W        = 13;
   localparam int CHK_MOD      = 255;
   localparam int ENABLE_AWB_BIT = 0;

   // gain math
   localparam int WORD_W     = 16;
   localparam int GAIN_SHIFT = 9;
   localparam int DIVIDEND_W = WORD_W + GAIN_SHIFT + 1;
   localparam int GAIN_W     = 25;
   localparam int NUM_COLS   = 3;
   localparam int NUM_SETS   = 2;

   localparam int QUEUE_DEPTH_DEF = 2;

   // color column codes
   localparam logic [1:0] COL_RED   = 2'd0;
   localparam logic [1:0] COL_GREEN = 2'd1;
   localparam logic [1:0] COL_BLUE  = 2'd2;

   typedef struct packed {
      logic                          ok;
      logic [1:0]                    enable;
      logic [CHAN_COUNT-1:0][7:0]    chan;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LOAD,
      B_MAX,
      B_START,
      B_WAIT,
      B_OUT
   } back_state_type;

endpackage

>>> hdl/awbgc_req_if.sv
interface awbgc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       record_start;

   modport source (output valid, output data_byte, output record_start, input ready);
   modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

>>> hdl/awbgc_rsp_if.sv
interface awbgc_rsp_if;
   logic        valid;
   logic        ready;
   logic        checksum_ok;
   logic [1:0]  enable_bits;
   logic        unit_set_valid;
   logic        golden_set_valid;
   logic [24:0] unit_gain_red;
   logic [24:0] unit_gain_green;
   logic [24:0] unit_gain_blue;
   logic [24:0] golden_gain_red;
   logic [24:0] golden_gain_green;
   logic [24:0] golden_gain_blue;

   modport source (
      output valid, output checksum_ok, output enable_bits,
      output unit_set_valid, output golden_set_valid,
      output unit_gain_red, output unit_gain_green, output unit_gain_blue,
      output golden_gain_red, output golden_gain_green, output golden_gain_blue,
      input ready
   );
   modport sink (
      input valid, input checksum_ok, input enable_bits,
      input unit_set_valid, input golden_set_valid,
      input unit_gain_red, input unit_gain_green, input unit_gain_blue,
      input golden_gain_red, input golden_gain_green, input golden_gain_blue,
      output ready
   );
endinterface

>>> hdl/awbgc_front.sv
module awbgc_front
   import awbgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   awbgc_req_if.sink   req,
   input  logic        q_full,
   output logic        push,
   output job_type     job
);

   logic [POS_W-1:0]      pos_ff, pos_in, pos_cur;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [1:0]            enable_ff, enable_in;
   logic [7:0]            chan_ff [CHAN_COUNT];
   logic                  accept;
   logic                  chan_we;
   logic [CHAN_IDX_W-1:0] chan_idx;
   logic [8:0]            fold;
   logic [8:0]            fold_mod;
   logic [8:0]            chk;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign pos_cur   = req.record_start ? '0 : pos_ff;
   assign chan_idx  = CHAN_IDX_W'(pos_cur - POS_W'(CHAN_FIRST));

   // sum mod 255: fold the high byte onto the low byte, one correction
   assign fold     = 9'(sum_ff[SUM_W-1:8]) + 9'(sum_ff[7:0]);
   assign fold_mod = (fold >= 9'(CHK_MOD)) ? fold - 9'(CHK_MOD) : fold;
   assign chk      = fold_mod + 9'd1;

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      enable_in = enable_ff;
      chan_we   = 1'b0;
      push      = 1'b0;
      if (accept) begin
         if (pos_cur >= POS_W'(RECORD_BYTES)) begin
            pos_in = POS_W'(RECORD_BYTES);
         end else begin
            pos_in = pos_cur + POS_W'(1);
            if (pos_cur == '0) begin
               enable_in = req.data_byte[7:6];
               sum_in    = '0;
            end else if (pos_cur < POS_W'(LAST_POS)) begin
               sum_in  = sum_ff + SUM_W'(req.data_byte);
               chan_we = (pos_cur >= POS_W'(CHAN_FIRST)) &&
                         (pos_cur < POS_W'(CHAN_FIRST + CHAN_COUNT));
            end else begin
               push = 1'b1;
            end
         end
      end
   end

   always_comb begin
      job.ok     = (chk == {1'b0, req.data_byte});
      job.enable = enable_ff;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         job.chan[i] = chan_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= '0;
         enable_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         enable_ff <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_ff[chan_idx] <= req.data_byte;
      end
   end

endmodule

>>> hdl/awbgc_queue.sv
module awbgc_queue
   import awbgc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/awbgc_div.sv
module awbgc_div
   import awbgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [WORD_W-1:0]     divisor,
   output logic                  done,
   output logic [GAIN_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   // restoring divider, one quotient bit per cycle
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WORD_W:0]       trial;
   logic [WORD_W:0]       diff;
   logic                  fits;

   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff     = trial - {1'b0, divisor};
   assign fits     = (trial >= {1'b0, divisor});
   assign done     = done_ff;
   assign quotient = quo_ff[GAIN_W-1:0];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

>>> hdl/awbgc_back.sv
module awbgc_back
   import awbgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  job_type     job,
   input  logic        q_empty,
   output logic        pop,
   awbgc_rsp_if.source rsp
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic           set_ff, set_in;
   logic [1:0]     col_ff, col_in;
   logic [WORD_W-1:0] r_ff, g_ff, b_ff, mx_ff;
   logic [WORD_W-1:0] r_w, g_w, b_w, gr_w, gb_w, mx_w;
   logic [WORD_W:0]   g_sum;
   logic [SET_BYTES-1:0][7:0] sb;
   logic           valid_ff [NUM_SETS];
   logic [GAIN_W-1:0] gain_ff [NUM_SETS][NUM_COLS];
   logic           set_ok;
   logic           load_we, max_we, gain_we, clear_all;
   logic           div_start, div_done;
   logic [WORD_W-1:0]     divisor;
   logic [DIVIDEND_W-1:0] dividend;
   logic [GAIN_W-1:0]     quotient;

   // pick the unit or golden half of the channel bytes
   assign sb    = set_ff ? job_ff.chan[CHAN_COUNT-1:SET_BYTES] : job_ff.chan[SET_BYTES-1:0];
   assign r_w   = {sb[0], sb[1]};
   assign gr_w  = {sb[2], sb[3]};
   assign gb_w  = {sb[4], sb[5]};
   assign b_w   = {sb[6], sb[7]};
   assign g_sum = (WORD_W+1)'(gr_w) + (WORD_W+1)'(gb_w) + (WORD_W+1)'(1);
   assign g_w   = g_sum[WORD_W:1];

   always_comb begin
      mx_w = r_ff;
      if (g_ff > mx_w) begin
         mx_w = g_ff;
      end
      if (b_ff > mx_w) begin
         mx_w = b_ff;
      end
   end

   assign set_ok = job_ff.ok && job_ff.enable[ENABLE_AWB_BIT] &&
                   (r_ff != '0) && (g_ff != '0) && (b_ff != '0);

   always_comb begin
      case (col_ff)
         COL_RED:   divisor = r_ff;
         COL_GREEN: divisor = g_ff;
         default:   divisor = b_ff;
      endcase
   end

   assign dividend = (DIVIDEND_W'(mx_ff) << GAIN_SHIFT) + DIVIDEND_W'(divisor >> 1);

   awbgc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      set_in    = set_ff;
      col_in    = col_ff;
      pop       = 1'b0;
      load_we   = 1'b0;
      max_we    = 1'b0;
      gain_we   = 1'b0;
      clear_all = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               clear_all = 1'b1;
               set_in    = 1'b0;
               state_in  = B_LOAD;
            end
         end
         B_LOAD: begin
            load_we  = 1'b1;
            state_in = B_MAX;
         end
         B_MAX: begin
            max_we = 1'b1;
            col_in = COL_RED;
            if (set_ok) begin
               state_in = B_START;
            end else if (!set_ff) begin
               set_in   = 1'b1;
               state_in = B_LOAD;
            end else begin
               state_in = B_OUT;
            end
         end
         B_START: begin
            div_start = 1'b1;
            state_in  = B_WAIT;
         end
         B_WAIT: begin
            if (div_done) begin
               gain_we = 1'b1;
               if (col_ff != COL_BLUE) begin
                  col_in   = col_ff + 2'd1;
                  state_in = B_START;
               end else if (!set_ff) begin
                  set_in   = 1'b1;
                  state_in = B_LOAD;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_OUT: begin
            if (rsp.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         set_ff   <= 1'b0;
         col_ff   <= COL_RED;
      end else begin
         state_ff <= state_in;
         set_ff   <= set_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= job;
      end
      if (load_we) begin
         r_ff <= r_w;
         g_ff <= g_w;
         b_ff <= b_w;
      end
      if (max_we) begin
         mx_ff            <= mx_w;
         valid_ff[set_ff] <= set_ok;
      end
      if (clear_all) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= 1'b0;
            for (int c = 0; c < NUM_COLS; c++) begin
               gain_ff[s][c] <= '0;
            end
         end
      end
      if (gain_we) begin
         gain_ff[set_ff][col_ff] <= quotient;
      end
   end

   assign rsp.valid             = (state_ff == B_OUT);
   assign rsp.checksum_ok       = job_ff.ok;
   assign rsp.enable_bits       = job_ff.enable;
   assign rsp.unit_set_valid    = valid_ff[0];
   assign rsp.golden_set_valid  = valid_ff[1];
   assign rsp.unit_gain_red     = gain_ff[0][COL_RED];
   assign rsp.unit_gain_green   = gain_ff[0][COL_GREEN];
   assign rsp.unit_gain_blue    = gain_ff[0][COL_BLUE];
   assign rsp.golden_gain_red   = gain_ff[1][COL_RED];
   assign rsp.golden_gain_green = gain_ff[1][COL_GREEN];
   assign rsp.golden_gain_blue  = gain_ff[1][COL_BLUE];

endmodule

>>> hdl/awb_otp_record_gain_calc_unit.sv
// Channel    Dir  Beat payload                                   Handshake
// ---------  ---  ---------------------------------------------  -----------
// req_chan   in   data_byte[7:0], record_start                   valid/ready
// rsp_chan   out  checksum_ok, enable_bits, set valid flags,     valid/ready
//                 six 25-bit gains (unit/golden x R/G/B)
//
// Cycles: one record byte per cycle while the job queue has room. After
//   byte 29 a record passes load/max steps, up to 6 divisions in the shared
//   26-step divider and the output step; fewer when a set is invalid.
// Reset: synchronous; byte position, running sum, enable field, queue and
//   back-end sequencer clear. Channel bytes and result payload do not.
// Stalls: req_chan.ready drops only when the job queue is full; rsp_chan
//   holds its beat until taken; the front keeps taking bytes until the queue fills.
module awb_otp_record_gain_calc_unit
   import awbgc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   awbgc_req_if.sink   req_chan,
   awbgc_rsp_if.source rsp_chan
);

   // front -> queue -> back
   job_type push_job;
   job_type pop_job;
   logic    push;
   logic    q_full;
   logic    pop;
   logic    q_empty;

   // byte intake, checksum, channel byte capture
   awbgc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   // finished records wait here for the gain sequencer
   awbgc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // R/G/B, max and up to six serial divisions, result register
   awbgc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .job     (pop_job),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

>>> sim/tb_awb_otp_record_gain_calc_unit.sv
`timescale 1ns / 1ps

// Testbench for the white-balance record gain unit.
// Bytes go in over req_if, one beat each. A local copy of the record
// parser predicts the single result that byte 29 of each record gives.
// Results coming out of rsp_if are checked in order against that list.
module tb_awb_otp_record_gain_calc_unit;
   import awbgc_pkg::*;

   localparam int RANDOM_RECORDS = 33;     // ~1250 bytes with the directed records
   localparam int IDLE_PCT       = 31;
   localparam int DRAIN_CYCLES   = 400;
   localparam int NUM_GAINS      = NUM_SETS * NUM_COLS;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } record_beat_type;

   typedef struct {
      logic              checksum_ok;
      logic [1:0]        enable_bits;
      logic              unit_ok;
      logic              golden_ok;
      logic [GAIN_W-1:0] gain [NUM_GAINS];   // unit R,G,B then golden R,G,B
   } awb_result_type;

   logic clock;
   logic reset;

   awbgc_req_if req_if();
   awbgc_rsp_if rsp_if();

   awb_otp_record_gain_calc_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // byte stream waiting to be driven, and results still owed by the block
   record_beat_type pending_beats [$];
   awb_result_type  expected_q [$];

   int fail_count     = 0;
   int accepted_beats = 0;
   logic req_took     = 1'b0;   // last posedge moved a request beat
   logic calm_stretch;

   // mirror of the record parser
   logic [POS_W-1:0] rec_pos    = '0;
   logic [SUM_W-1:0] rec_sum    = '0;
   logic [1:0]       rec_enable = '0;
   logic [7:0]       cal_bytes [CHAN_COUNT] = '{default: '0};

   string gain_names [NUM_GAINS] = '{
      "unit_gain_red", "unit_gain_green", "unit_gain_blue",
      "golden_gain_red", "golden_gain_green", "golden_gain_blue"
   };

   // no idling on either side for a window of beats mid-run
   assign calm_stretch = (accepted_beats >= 500) && (accepted_beats < 800);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // gains for one set of R, Gr, Gb, B words starting at cal_bytes[base]
   function automatic bit calc_gains(input int base, output logic [GAIN_W-1:0] g_red,
                                     output logic [GAIN_W-1:0] g_green,
                                     output logic [GAIN_W-1:0] g_blue);
      int unsigned red, gr, gb, green, blue, peak;
      red   = {cal_bytes[base],     cal_bytes[base + 1]};
      gr    = {cal_bytes[base + 2], cal_bytes[base + 3]};
      gb    = {cal_bytes[base + 4], cal_bytes[base + 5]};
      blue  = {cal_bytes[base + 6], cal_bytes[base + 7]};
      green = (gr + gb + 1) >> 1;
      g_red   = '0;
      g_green = '0;
      g_blue  = '0;
      if (red == 0 || green == 0 || blue == 0) return 1'b0;
      peak = red;
      if (green > peak) peak = green;
      if (blue > peak) peak = blue;
      g_red   = GAIN_W'(((peak << GAIN_SHIFT) + red / 2) / red);
      g_green = GAIN_W'(((peak << GAIN_SHIFT) + green / 2) / green);
      g_blue  = GAIN_W'(((peak << GAIN_SHIFT) + blue / 2) / blue);
      return 1'b1;
   endfunction

   // advance the parser by one byte; returns 1 when byte 29 yields a result
   function automatic bit take_record_byte(input logic [7:0] data, input logic start,
                                           output awb_result_type res);
      int pos;
      logic [7:0] chk;
      res = '{checksum_ok: 1'b0, enable_bits: 2'b00, unit_ok: 1'b0, golden_ok: 1'b0,
              gain: '{default: '0}};
      pos = start ? 0 : int'(rec_pos);
      if (pos >= RECORD_BYTES) begin
         rec_pos = POS_W'(RECORD_BYTES);     // past the end: byte dropped
         return 1'b0;
      end
      rec_pos = POS_W'(pos + 1);
      if (pos == 0) begin
         rec_enable = data[7:6];
         rec_sum    = '0;
         return 1'b0;
      end
      if (pos < LAST_POS) begin
         rec_sum = rec_sum + SUM_W'(data);
         if (pos >= CHAN_FIRST) cal_bytes[pos - CHAN_FIRST] = data;
         return 1'b0;
      end
      chk = 8'(rec_sum % CHK_MOD + 1);
      res.checksum_ok = (chk == data);
      res.enable_bits = rec_enable;
      if (res.checksum_ok && rec_enable[ENABLE_AWB_BIT]) begin
         res.unit_ok   = calc_gains(0, res.gain[0], res.gain[1], res.gain[2]);
         res.golden_ok = calc_gains(SET_BYTES, res.gain[3], res.gain[4], res.gain[5]);
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------

   function automatic logic [15:0] random_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) return '0;                          // zero R or B kills the set; G needs Gr and Gb zero
      if (roll < 20) return 16'($urandom_range(1, 15)); // tiny channel, huge gain
      if (roll < 28) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // full 30-byte record; fill < 0 means random bytes 1..12
   task automatic queue_record(input logic [1:0] en, input logic [15:0] words [8],
                               input bit lead_start, input bit bad_sum, input int fill);
      logic [7:0] rec [RECORD_BYTES];
      int total;
      logic [7:0] chk;
      total  = 0;
      rec[0] = {en, 6'($urandom)};
      for (int i = 1; i < CHAN_FIRST; i++)
         rec[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
      for (int i = 0; i < CHAN_COUNT / 2; i++) begin
         rec[CHAN_FIRST + 2 * i]     = words[i][15:8];
         rec[CHAN_FIRST + 2 * i + 1] = words[i][7:0];
      end
      for (int i = 1; i < LAST_POS; i++) total += rec[i];
      chk = 8'(total % CHK_MOD + 1);
      if (bad_sum) chk = chk + 8'($urandom_range(1, 255));
      rec[LAST_POS] = chk;
      for (int i = 0; i < RECORD_BYTES; i++)
         pending_beats.push_back('{data: rec[i], start: (i == 0) && lead_start});
   endtask

   // start of a record that gets cut off by the next record_start
   task automatic queue_partial(input int len);
      for (int i = 0; i < len; i++)
         pending_beats.push_back('{data: 8'($urandom), start: (i == 0)});
   endtask

   // stray bytes after byte 29 with no new start; the block drops them
   task automatic queue_trailing(input int len);
      for (int i = 0; i < len; i++)
         pending_beats.push_back('{data: 8'($urandom), start: 1'b0});
   endtask

   task automatic check_field(input string name, input logic [GAIN_W-1:0] want,
                              input logic [GAIN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: request beats change on the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      record_beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (pending_beats.size() != 0 &&
             (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
            beat = pending_beats.pop_front();
            req_if.valid        <= 1'b1;
            req_if.data_byte    <= beat.data;
            req_if.record_start <= beat.start;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result back-pressure, same idle rate
   always @(negedge clock) begin
      rsp_if.ready <= !reset && (calm_stretch || $urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------
   // monitor: everything sampled on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      awb_result_type res;
      awb_result_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            accepted_beats++;
            if (take_record_byte(req_if.data_byte, req_if.record_start, res))
               expected_q.push_back(res);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               $error("result beat with no record pending");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("checksum_ok", want.checksum_ok, rsp_if.checksum_ok);
               check_field("enable_bits", want.enable_bits, rsp_if.enable_bits);
               check_field("unit_set_valid", want.unit_ok, rsp_if.unit_set_valid);
               check_field("golden_set_valid", want.golden_ok, rsp_if.golden_set_valid);
               check_field(gain_names[0], want.gain[0], rsp_if.unit_gain_red);
               check_field(gain_names[1], want.gain[1], rsp_if.unit_gain_green);
               check_field(gain_names[2], want.gain[2], rsp_if.unit_gain_blue);
               check_field(gain_names[3], want.gain[3], rsp_if.golden_gain_red);
               check_field(gain_names[4], want.gain[4], rsp_if.golden_gain_green);
               check_field(gain_names[5], want.gain[5], rsp_if.golden_gain_blue);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int kind;
      logic [15:0] words [8];
      logic [1:0] en;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.data_byte    = '0;
      req_if.record_start = 1'b0;
      rsp_if.ready        = 1'b0;

      // first record has no record_start: byte 0 is taken from position zero.
      // unit set R=B=1, G=FFFF gives the largest gain; golden all FFFF gives 512.
      queue_record(2'd3, '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b0, 8'hFF);
      // bad checksum with AWB on
      queue_record(2'd1, '{16'h1234, 16'h0800, 16'h0801, 16'h0F00,
                           16'h0400, 16'h0300, 16'h0300, 16'h0500}, 1'b1, 1'b1, 8'h00);
      // AWB bit clear: AF only, then nothing enabled
      queue_record(2'd2, '{16'h0100, 16'h0200, 16'h0200, 16'h0300,
                           16'h0100, 16'h0200, 16'h0200, 16'h0300}, 1'b1, 1'b0, -1);
      queue_record(2'd0, '{16'h0100, 16'h0200, 16'h0200, 16'h0300,
                           16'h0100, 16'h0200, 16'h0200, 16'h0300}, 1'b1, 1'b0, -1);
      // zero unit red; golden green rounds up from Gr=0, Gb=1
      queue_record(2'd1, '{16'h0000, 16'h0400, 16'h0400, 16'h0400,
                           16'h0003, 16'h0000, 16'h0001, 16'h0002}, 1'b1, 1'b0, -1);
      // zero green from both halves; golden blue zero; odd Gr+Gb rounding
      queue_record(2'd3, '{16'h0200, 16'h0000, 16'h0000, 16'h0200,
                           16'h0010, 16'h0001, 16'h0002, 16'h0000}, 1'b1, 1'b0, -1);
      // record cut short by a new start, then a good one with stray bytes after
      queue_partial(10);
      queue_record(2'd1, '{16'h7FFF, 16'h8000, 16'h8001, 16'hFFFE,
                           16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA}, 1'b1, 1'b0, -1);
      queue_trailing(3);

      // random records, mostly well formed so the gain path sees real data
      repeat (RANDOM_RECORDS) begin
         kind = $urandom_range(99);
         for (int i = 0; i < 8; i++) words[i] = random_word();
         if (kind < 7) queue_partial($urandom_range(1, LAST_POS));
         en = (kind >= 7 && kind < 15) ? {1'($urandom), 1'b0} : {1'($urandom), 1'b1};
         queue_record(en, words, 1'b1, (kind >= 15 && kind < 23), -1);
         if (kind >= 23 && kind < 30) queue_trailing($urandom_range(1, 4));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_if.valid) @(negedge clock);
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("awb_otp_record_gain_calc_unit test passed");
      end else begin
         $display("awb_otp_record_gain_calc_unit test failed");
      end
      $finish;
   end

   // hang guard: a clean run needs well under a tenth of this
   initial begin
      #2_000_000;
      $display("awb_otp_record_gain_calc_unit test failed");
      $finish;
   end

endmodule

>>> filelist.f
hdl/awbgc_pkg.sv
hdl/awbgc_req_if.sv
hdl/awbgc_rsp_if.sv
hdl/awbgc_front.sv
hdl/awbgc_queue.sv
hdl/awbgc_div.sv
hdl/awbgc_back.sv
hdl/awb_otp_record_gain_calc_unit.sv
sim/tb_awb_otp_record_gain_calc_unit.sv
